// ===== src/lrs_pkg.sv =====
`default_nettype none
package lrs_pkg;

    // Destination geometry
    localparam int unsigned DEST_SIZE  = 320;
    localparam int unsigned COORD_W    = $clog2(DEST_SIZE + 1);
    localparam int unsigned DIM_W      = 12;
    localparam int unsigned ADDR_W     = 22;
    localparam int unsigned INV_W      = DIM_W + 17 - $clog2(2 * DEST_SIZE) + 1;
    localparam int unsigned DIV_NUM_W  = DIM_W + 17;
    localparam int unsigned DIV_DEN_W  = DIM_W + 1;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_NUM_W);
    localparam int unsigned PROD_W     = COORD_W + INV_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = DIM_W;

    localparam logic [DIV_DEN_W-1:0] TWO_DEST = DIV_DEN_W'(2 * DEST_SIZE);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 2'd2;

    // Geometry division steps
    localparam logic [1:0] GEO_INV = 2'd0;
    localparam logic [1:0] GEO_AW  = 2'd1;
    localparam logic [1:0] GEO_AH  = 2'd2;

    // Result kinds on the output channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // RGB565 widening constants
    localparam logic [9:0] R_MUL = 10'd527;
    localparam logic [4:0] R_ADD = 5'd23;
    localparam logic [8:0] G_MUL = 9'd259;
    localparam logic [5:0] G_ADD = 6'd33;

    typedef enum logic [1:0] {
        EMIT_PAD   = 2'd0,
        EMIT_PIX   = 2'd1,
        EMIT_FETCH = 2'd2
    } emit_kind_t;

    typedef struct packed {
        logic       capture;
        logic       geo_start;
        logic       geo_store;
        logic       geo_fin;
        logic       map;
        logic       addr;
        logic       emit;
        emit_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic awaiting;
        logic geo_ready;
        logic div_done;
        logic geo_last;
        logic active;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== src/lrs_div.sv =====
`default_nettype none
module lrs_div (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            start,
    input  wire [lrs_pkg::DIV_NUM_W-1:0]   numerator,
    input  wire [lrs_pkg::DIV_DEN_W-1:0]   denominator,
    output logic                           done,
    output logic [lrs_pkg::DIV_NUM_W-1:0]  quotient
);
    import lrs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quot_reg[DIV_NUM_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            quot_next = numerator;
            rem_next  = '0;
            den_next  = denominator;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_DEN_W-1:0];
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// ===== src/lrs_ctrl.sv =====
`default_nettype none
module lrs_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    input  wire               s_opcode,
    output logic              s_ready,
    input  lrs_pkg::status_t  status,
    output lrs_pkg::cmd_t     cmd
);
    import lrs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_GEO_START  = 10'b00_0000_0010,
        S_GEO_RUN    = 10'b00_0000_0100,
        S_GEO_FIN    = 10'b00_0000_1000,
        S_CHECK      = 10'b00_0001_0000,
        S_MAP        = 10'b00_0010_0000,
        S_ADDR       = 10'b00_0100_0000,
        S_EMIT_PAD   = 10'b00_1000_0000,
        S_EMIT_PIX   = 10'b01_0000_0000,
        S_EMIT_FETCH = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = EMIT_PAD;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_opcode) begin
                        // drop a returned pixel that nobody asked for
                        state_next = status.awaiting ? S_EMIT_PIX : S_IDLE;
                    end else if (status.awaiting) begin
                        state_next = S_MAP;
                    end else if (!status.geo_ready) begin
                        state_next = S_GEO_START;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_GEO_START: begin
                cmd.geo_start = 1'b1;
                state_next    = S_GEO_RUN;
            end
            S_GEO_RUN: begin
                if (status.div_done) begin
                    cmd.geo_store = 1'b1;
                    state_next    = status.geo_last ? S_GEO_FIN : S_GEO_START;
                end
            end
            S_GEO_FIN: begin
                cmd.geo_fin = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK: begin
                state_next = status.active ? S_MAP : S_EMIT_PAD;
            end
            S_MAP: begin
                cmd.map    = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = S_EMIT_FETCH;
            end
            S_EMIT_PAD: begin
                cmd.kind = EMIT_PAD;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_PIX: begin
                cmd.kind = EMIT_PIX;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_FETCH: begin
                cmd.kind = EMIT_FETCH;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/lrs_dp.sv =====
`default_nettype none
module lrs_dp (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire [lrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [lrs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire [15:0]                       s_source_pixel,
    input  lrs_pkg::cmd_t                    cmd,
    output lrs_pkg::status_t                 status,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_kind,
    output logic [lrs_pkg::ADDR_W-1:0]       m_fetch_address,
    output logic signed [7:0]                m_red_q,
    output logic signed [7:0]                m_green_q,
    output logic signed [7:0]                m_blue_q,
    output logic                             m_frame_end
);
    import lrs_pkg::*;

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [7:0]       pad_reg;

    // scan and geometry state
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [COORD_W-1:0] aw_reg, ah_reg, lpad_reg, tpad_reg;
    logic [INV_W-1:0]   inv_reg;
    logic               awaiting_reg, geo_ready_reg;
    logic [1:0]         step_reg;

    logic [15:0]        pix_reg;
    logic [PROD_W-1:0]  xprod_reg, yprod_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [7:0]         out_r_reg, out_g_reg, out_b_reg;
    logic               out_end_reg;

    logic [DIM_W-1:0]     dim_w, dim_h, big;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [COORD_W-1:0]   fit_val;
    logic [COORD_W-1:0]   dx, dy;
    logic [COORD_W:0]     x_end, y_end;
    logic [PROD_W:0]      xs_sum, ys_sum;
    logic [PROD_W-16:0]   xs, ys;
    logic [DIM_W-1:0]     sx, sy;
    logic [2*DIM_W:0]     addr_full;
    logic                 out_free, last_px;
    logic [13:0]          r_wide, b_wide;
    logic [14:0]          g_wide;
    logic [7:0]           r8, g8, b8;

    assign dim_w = (width_reg == '0) ? DIM_W'(1) : width_reg;
    assign dim_h = (height_reg == '0) ? DIM_W'(1) : height_reg;
    assign big   = (dim_w > dim_h) ? dim_w : dim_h;

    // divider operands per geometry step
    always_comb begin
        unique case (step_reg)
            GEO_INV: begin
                div_num = {big, 17'd0} + DIV_NUM_W'(DEST_SIZE);
                div_den = TWO_DEST;
            end
            GEO_AW: begin
                div_num = DIV_NUM_W'(dim_w) * DIV_NUM_W'(2 * DEST_SIZE) + DIV_NUM_W'(big);
                div_den = {big, 1'b0};
            end
            default: begin
                div_num = DIV_NUM_W'(dim_h) * DIV_NUM_W'(2 * DEST_SIZE) + DIV_NUM_W'(big);
                div_den = {big, 1'b0};
            end
        endcase
    end

    lrs_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cmd.geo_start),
        .numerator   (div_num),
        .denominator (div_den),
        .done        (div_done),
        .quotient    (div_quot)
    );

    assign fit_val = (div_quot > DIV_NUM_W'(DEST_SIZE)) ? COORD_W'(DEST_SIZE)
                                                       : div_quot[COORD_W-1:0];

    // source coordinate mapping
    assign dx     = col_reg - lpad_reg;
    assign dy     = row_reg - tpad_reg;
    assign x_end  = {1'b0, lpad_reg} + {1'b0, aw_reg};
    assign y_end  = {1'b0, tpad_reg} + {1'b0, ah_reg};
    assign xs_sum = {1'b0, xprod_reg} + (PROD_W+1)'(32768);
    assign ys_sum = {1'b0, yprod_reg} + (PROD_W+1)'(32768);
    assign xs     = xs_sum[PROD_W:16];
    assign ys     = ys_sum[PROD_W:16];
    assign sx     = (xs >= (PROD_W-15)'(dim_w)) ? dim_w - 1'b1 : DIM_W'(xs);
    assign sy     = (ys >= (PROD_W-15)'(dim_h)) ? dim_h - 1'b1 : DIM_W'(ys);
    assign addr_full = (2*DIM_W+1)'(sy) * (2*DIM_W+1)'(dim_w) + (2*DIM_W+1)'(sx);

    // RGB565 widening
    assign r_wide = 14'(pix_reg[15:11]) * 14'(R_MUL) + 14'(R_ADD);
    assign g_wide = 15'(pix_reg[10:5]) * 15'(G_MUL) + 15'(G_ADD);
    assign b_wide = 14'(pix_reg[4:0]) * 14'(R_MUL) + 14'(R_ADD);
    assign r8     = r_wide[13:6];
    assign g8     = g_wide[13:6];
    assign b8     = b_wide[13:6];

    assign out_free = !out_valid_reg || m_ready;
    assign last_px  = (col_reg == COORD_W'(DEST_SIZE - 1)) &&
                      (row_reg == COORD_W'(DEST_SIZE - 1));

    assign status.awaiting  = awaiting_reg;
    assign status.geo_ready = geo_ready_reg;
    assign status.div_done  = div_done;
    assign status.geo_last  = (step_reg == GEO_AH);
    assign status.active    = (col_reg >= lpad_reg) && ({1'b0, col_reg} < x_end) &&
                              (row_reg >= tpad_reg) && ({1'b0, row_reg} < y_end);
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            pad_reg       <= 8'd128;
            col_reg       <= '0;
            row_reg       <= '0;
            aw_reg        <= '0;
            ah_reg        <= '0;
            lpad_reg      <= '0;
            tpad_reg      <= '0;
            inv_reg       <= '0;
            awaiting_reg  <= 1'b0;
            geo_ready_reg <= 1'b0;
            step_reg      <= GEO_INV;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_HEIGHT: height_reg <= cfg_wdata;
                    CFG_PAD:    pad_reg    <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (cmd.geo_store) begin
                case (step_reg)
                    GEO_INV: inv_reg <= div_quot[INV_W-1:0];
                    GEO_AW:  aw_reg  <= fit_val;
                    default: ah_reg  <= fit_val;
                endcase
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.geo_fin) begin
                lpad_reg      <= (COORD_W'(DEST_SIZE) - aw_reg) >> 1;
                tpad_reg      <= (COORD_W'(DEST_SIZE) - ah_reg) >> 1;
                geo_ready_reg <= 1'b1;
                step_reg      <= GEO_INV;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                if (cmd.kind == EMIT_FETCH) begin
                    awaiting_reg <= 1'b1;
                end else begin
                    awaiting_reg <= 1'b0;
                    // advance the raster scan, wrap at frame end
                    if (last_px) begin
                        col_reg       <= '0;
                        row_reg       <= '0;
                        geo_ready_reg <= 1'b0;
                    end else if (col_reg == COORD_W'(DEST_SIZE - 1)) begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end

        if (cmd.capture) begin
            pix_reg <= s_source_pixel;
        end
        if (cmd.map) begin
            xprod_reg <= PROD_W'(dx) * PROD_W'(inv_reg);
            yprod_reg <= PROD_W'(dy) * PROD_W'(inv_reg);
        end
        if (cmd.addr) begin
            addr_reg <= addr_full[ADDR_W-1:0];
        end
        if (cmd.emit) begin
            unique case (cmd.kind)
                EMIT_FETCH: begin
                    out_kind_reg <= KIND_FETCH;
                    out_addr_reg <= addr_reg;
                    out_r_reg    <= '0;
                    out_g_reg    <= '0;
                    out_b_reg    <= '0;
                    out_end_reg  <= 1'b0;
                end
                EMIT_PIX: begin
                    out_kind_reg <= KIND_PIXEL;
                    out_addr_reg <= '0;
                    out_r_reg    <= r8 ^ 8'h80;
                    out_g_reg    <= g8 ^ 8'h80;
                    out_b_reg    <= b8 ^ 8'h80;
                    out_end_reg  <= last_px;
                end
                default: begin
                    out_kind_reg <= KIND_PIXEL;
                    out_addr_reg <= '0;
                    out_r_reg    <= pad_reg ^ 8'h80;
                    out_g_reg    <= pad_reg ^ 8'h80;
                    out_b_reg    <= pad_reg ^ 8'h80;
                    out_end_reg  <= last_px;
                end
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_fetch_address = out_addr_reg;
    assign m_red_q         = out_r_reg;
    assign m_green_q       = out_g_reg;
    assign m_blue_q        = out_b_reg;
    assign m_frame_end     = out_end_reg;

endmodule
`default_nettype wire

// ===== src/letterbox_resize_rgb565_to_int8_core.sv =====
// Letterbox resize of an RGB565 source into a 320x320 signed 8-bit RGB frame.
// Input channel (s_*): opcode 0 asks for the next destination pixel, opcode 1
// returns the source pixel that the last fetch request asked for.
// Output channel (m_*): kind 0 is a finished pixel (frame_end on the last one
// of the frame), kind 1 is a fetch request carrying row*width+column.
// Configuration: write width, height and pad level through cfg_* while idle.
// Throughput: one item at a time; a new item is taken only after the last
// one's result is registered. A pad pixel goes through the check and emit
// steps, a returned pixel straight to emit, a fetch request through check (not
// for a repeat), map, address and emit; a dropped return gives no result. The
// first advance of a frame also runs three serial divisions on the shared divider.
// An advance while a fetch is outstanding repeats the same fetch request.
// Reset: synchronous, aresetn low; registers return to 640, 480 and 128,
// the scan restarts at the top left and geometry is recomputed.
// Stall: a result waits in the output register while m_ready is low; the block
// still takes the next item but holds in its emit step until the register drains.
`default_nettype none
module letterbox_resize_rgb565_to_int8_core (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire [lrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [lrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_opcode,
    input  wire [15:0]                      s_source_pixel,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_kind,
    output logic [lrs_pkg::ADDR_W-1:0]      m_fetch_address,
    output logic signed [7:0]               m_red_q,
    output logic signed [7:0]               m_green_q,
    output logic signed [7:0]               m_blue_q,
    output logic                            m_frame_end
);
    import lrs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequence each item: capture, geometry, mapping, emit
    lrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold scan state, geometry, divider and the output register
    lrs_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_source_pixel  (s_source_pixel),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_fetch_address (m_fetch_address),
        .m_red_q         (m_red_q),
        .m_green_q       (m_green_q),
        .m_blue_q        (m_blue_q),
        .m_frame_end     (m_frame_end)
    );

`ifndef NO_ASSERTIONS
    a_fetch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_FETCH) |->
        (!m_frame_end && m_red_q == 8'sd0 && m_green_q == 8'sd0 && m_blue_q == 8'sd0))
        else $error("fetch request carries pixel data");

    a_geo_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(status.geo_ready) |-> ($past(cmd.emit) && m_frame_end))
        else $error("geometry dropped outside frame end");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result emitted over a pending one");
`endif

endmodule
`default_nettype wire

// ===== dv/letterbox_resize_rgb565_to_int8_core_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module letterbox_resize_rgb565_to_int8_core_test;
    import lrs_pkg::*;

    localparam int unsigned DEST   = 320;
    localparam int unsigned SETTLE = 120;  // covers the three geometry divisions

    typedef struct packed {
        logic        kind;
        logic [21:0] addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        frame_end;
    } resize_out_t;

    typedef enum logic [1:0] {ROW_ADV, ROW_PIX, ROW_CFG, ROW_SEEK} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_e;

    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        int unsigned          data;
        chk_e                 chk;
        resize_out_t          want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_opcode = 1'b0;
    logic [15:0]           s_source_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_kind;
    logic [ADDR_W-1:0]     m_fetch_address;
    logic signed [7:0]     m_red_q;
    logic signed [7:0]     m_green_q;
    logic signed [7:0]     m_blue_q;
    logic                  m_frame_end;

    letterbox_resize_rgb565_to_int8_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_source_pixel (s_source_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_fetch_address(m_fetch_address),
        .m_red_q        (m_red_q),
        .m_green_q      (m_green_q),
        .m_blue_q       (m_blue_q),
        .m_frame_end    (m_frame_end)
    );

    always #5 aclk = ~aclk;

    // Shadow of the block: registers, scan position and latched geometry
    int unsigned     width_reg, height_reg, pad_reg;
    int unsigned     scan_col, scan_row, act_w, act_h, pad_left, pad_top;
    longint unsigned inv_scale;
    bit              fetch_pending, geo_valid;
    int unsigned     frames_done;

    resize_out_t     pixel_q[$];   // results still owed by the block
    resize_out_t     last_res;
    bit              last_got;
    int unsigned     err_count;
    bit              idle_on;
    bit              hold_req;

    function automatic int unsigned eff_dim(input int unsigned d);
        return (d == 0) ? 1 : d;
    endfunction

    function automatic int unsigned fit_len(input int unsigned d, input int unsigned big);
        longint unsigned s;
        s = (64'd2 * d * DEST + big) / (64'd2 * big);
        return (s > DEST) ? DEST : int'(s);
    endfunction

    function automatic longint unsigned src_coord(input int unsigned d, input int unsigned lim);
        longint unsigned s;
        s = (d * inv_scale + 64'd32768) >> 16;
        return (s >= lim) ? lim - 1 : s;
    endfunction

    function automatic resize_out_t make_pixel(input int unsigned r, g, b);
        resize_out_t o;
        o = '0;
        o.kind      = KIND_PIXEL;
        o.red       = 8'(r) ^ 8'h80;
        o.green     = 8'(g) ^ 8'h80;
        o.blue      = 8'(b) ^ 8'h80;
        o.frame_end = (scan_col == DEST - 1) && (scan_row == DEST - 1);
        if (o.frame_end) begin
            scan_col   = 0;
            scan_row   = 0;
            geo_valid  = 1'b0;
            frames_done++;
        end else if (scan_col + 1 >= DEST) begin
            scan_col = 0;
            scan_row++;
        end else begin
            scan_col++;
        end
        return o;
    endfunction

    function automatic resize_out_t make_fetch();
        resize_out_t     o;
        longint unsigned sx, sy;
        sx = src_coord(scan_col - pad_left, eff_dim(width_reg));
        sy = src_coord(scan_row - pad_top, eff_dim(height_reg));
        o = '0;
        o.kind = KIND_FETCH;
        o.addr = 22'(sy * eff_dim(width_reg) + sx);
        return o;
    endfunction

    // Advance the shadow by one accepted item; got is low when nothing comes out
    task automatic resize_step(input logic op, input logic [15:0] px,
                               output bit got, output resize_out_t res);
        int unsigned w, h, big, r5, g6, b5;
        got = 1'b1;
        res = '0;
        if (op == 1'b0) begin
            if (fetch_pending) begin
                res = make_fetch();
                return;
            end
            if (!geo_valid) begin
                w         = eff_dim(width_reg);
                h         = eff_dim(height_reg);
                big       = (w > h) ? w : h;
                inv_scale = (64'(big) * 131072 + DEST) / (2 * DEST);
                act_w     = fit_len(w, big);
                act_h     = fit_len(h, big);
                pad_left  = (DEST - act_w) / 2;
                pad_top   = (DEST - act_h) / 2;
                geo_valid = 1'b1;
            end
            if (scan_col >= pad_left && scan_col < pad_left + act_w &&
                scan_row >= pad_top && scan_row < pad_top + act_h) begin
                res = make_fetch();
                fetch_pending = 1'b1;
            end else begin
                res = make_pixel(pad_reg, pad_reg, pad_reg);
            end
            return;
        end
        if (!fetch_pending) begin
            got = 1'b0;
            return;
        end
        fetch_pending = 1'b0;
        r5 = px[15:11];
        g6 = px[10:5];
        b5 = px[4:0];
        res = make_pixel(((r5 * 527 + 23) >> 6) & 255, ((g6 * 259 + 33) >> 6) & 255,
                         ((b5 * 527 + 23) >> 6) & 255);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_px();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int unsigned rand_dim();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return 7;
            3: return 2048;
            4: return 4095;
            default: return $urandom_range(1, 2048);
        endcase
    endfunction

    // Offer one item, hold it until taken, then book its result
    task automatic offer(input logic op, input logic [15:0] px, input chk_e chk,
                         input resize_out_t want);
        int unsigned g;
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_source_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        resize_step(op, px, last_got, last_res);
        case (chk)
            CHK_TYPED: pixel_q.push_back(want);
            CHK_NONE:  ;
            default:   if (last_got) pixel_q.push_back(last_res);
        endcase
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Write one register with the block drained and quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        s_valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg  = value & 12'hFFF;
            CFG_HEIGHT: height_reg = value & 12'hFFF;
            CFG_PAD:    pad_reg    = value & 8'hFF;
            default:    ;
        endcase
    endtask

    // Well-formed traffic most of the time: answer an open fetch, else advance.
    // Returns 1 when the item does something.
    task automatic random_item(input bit noisy, output bit counted);
        int unsigned r;
        logic        op;
        r       = $urandom_range(0, 99);
        counted = 1'b1;
        if (fetch_pending) begin
            op = (noisy && r >= 85) ? 1'b0 : 1'b1;   // advance while awaiting repeats
        end else begin
            op = (noisy && r >= 90);                  // stray return is ignored
            counted = !op;
        end
        offer(op, rand_px(), CHK_MODEL, '0);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest one owed
    always @(posedge aclk) begin
        resize_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected result kind=%0d addr=%0d", m_kind, m_fetch_address);
                err_count++;
            end else begin
                e = pixel_q.pop_front();
                if (m_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_kind);
                    err_count++;
                end
                if (m_fetch_address !== e.addr) begin
                    $error("fetch_address: expected %0d, got %0d", e.addr, m_fetch_address);
                    err_count++;
                end
                if (m_red_q !== e.red) begin
                    $error("red_q: expected %0d, got %0d", $signed(e.red), m_red_q);
                    err_count++;
                end
                if (m_green_q !== e.green) begin
                    $error("green_q: expected %0d, got %0d", $signed(e.green), m_green_q);
                    err_count++;
                end
                if (m_blue_q !== e.blue) begin
                    $error("blue_q: expected %0d, got %0d", $signed(e.blue), m_blue_q);
                    err_count++;
                end
                if (m_frame_end !== e.frame_end) begin
                    $error("frame_end: expected %0d, got %0d", e.frame_end, m_frame_end);
                    err_count++;
                end
            end
        end
    end

    // Generous cap: one full frame plus the random part is well under this
    initial begin
        #20_000_000;
        $display("letterbox_resize_rgb565_to_int8_core_test NOT OK");
        $finish;
    end

    initial begin
        stim_row_t   rows[$];
        resize_out_t typed;
        int unsigned done_items, f0;
        bit          cnt;

        width_reg = 640; height_reg = 480; pad_reg = 128;
        scan_col = 0; scan_row = 0; act_w = 0; act_h = 0;
        pad_left = 0; pad_top = 0; inv_scale = 0;
        fetch_pending = 0; geo_valid = 0; frames_done = 0;
        err_count = 0; idle_on = 1; hold_req = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The first frame latches a 7 x 4095 geometry: one active
        // column in the middle of every row, the rest letterbox padding.
        typed = '0;
        rows.push_back('{ROW_CFG, CFG_WIDTH, 7, CHK_MODEL, '0});
        rows.push_back('{ROW_CFG, CFG_HEIGHT, 4095, CHK_MODEL, '0});
        // pad level at reset is mid-gray, which is zero after the offset
        rows.push_back('{ROW_ADV, 0, 0, CHK_TYPED, '{KIND_PIXEL, 0, 0, 0, 0, 0}});
        // a return with nothing requested is dropped
        rows.push_back('{ROW_PIX, 0, 16'hFFFF, CHK_NONE, '0});
        rows.push_back('{ROW_CFG, CFG_PAD, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_ADV, 0, 0, CHK_TYPED, '{KIND_PIXEL, 0, 8'h80, 8'h80, 8'h80, 0}});
        rows.push_back('{ROW_CFG, CFG_PAD, 255, CHK_MODEL, '0});
        rows.push_back('{ROW_ADV, 0, 0, CHK_TYPED, '{KIND_PIXEL, 0, 8'h7F, 8'h7F, 8'h7F, 0}});
        rows.push_back('{ROW_SEEK, 0, 0, CHK_MODEL, '0});
        // advance while awaiting repeats the same top-left fetch
        rows.push_back('{ROW_ADV, 0, 0, CHK_TYPED, '{KIND_FETCH, 0, 0, 0, 0, 0}});
        rows.push_back('{ROW_PIX, 0, 16'hFFFF, CHK_TYPED, '{KIND_PIXEL, 0, 8'h7F, 8'h7F, 8'h7F, 0}});
        rows.push_back('{ROW_SEEK, 0, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_PIX, 0, 16'h0000, CHK_TYPED, '{KIND_PIXEL, 0, 8'h80, 8'h80, 8'h80, 0}});
        // zero width counts as one; latched geometry stays, addressing follows
        rows.push_back('{ROW_CFG, CFG_WIDTH, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_SEEK, 0, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_PIX, 0, 16'hF800, CHK_MODEL, '0});
        rows.push_back('{ROW_CFG, CFG_WIDTH, 4095, CHK_MODEL, '0});
        rows.push_back('{ROW_SEEK, 0, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_PIX, 0, 16'h07E0, CHK_MODEL, '0});
        rows.push_back('{ROW_SEEK, 0, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_PIX, 0, 16'h001F, CHK_MODEL, '0});
        rows.push_back('{ROW_CFG, CFG_HEIGHT, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_SEEK, 0, 0, CHK_MODEL, '0});
        rows.push_back('{ROW_PIX, 0, 16'hAAAA, CHK_MODEL, '0});
        rows.push_back('{ROW_PIX, 0, 16'h5555, CHK_NONE, '0});

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_CFG: write_reg(rows[i].idx, rows[i].data);
                ROW_ADV: offer(1'b0, rand_px(), rows[i].chk, rows[i].want);
                ROW_PIX: offer(1'b1, 16'(rows[i].data), rows[i].chk, rows[i].want);
                default: begin
                    // advance through padding up to the next fetch request
                    do offer(1'b0, rand_px(), CHK_MODEL, '0);
                    while (!(last_got && last_res.kind == KIND_FETCH));
                end
            endcase
        end

        // Random part: chunks under fresh register settings, block idle between
        done_items = 0;
        for (int chunk = 0; chunk < 7; chunk++) begin
            write_reg(CFG_WIDTH, rand_dim());
            write_reg(CFG_HEIGHT, rand_dim());
            write_reg(CFG_PAD, (chunk == 1) ? 0 : (chunk == 2) ? 255 : $urandom_range(0, 255));
            idle_on = (chunk != 4);   // one stretch at full rate
            for (int n = 0; n < 150; ) begin
                if (chunk == 3 && n == 40) hold_req = 1'b1;  // fill up and stall input
                random_item(1'b1, cnt);
                if (cnt) n++;
            end
            done_items += 150;
        end

        // Walk out the frame at full rate. Widest addressing on the latched
        // geometry pushes deep rows past the 22-bit address range.
        write_reg(CFG_WIDTH, 4095);
        write_reg(CFG_HEIGHT, 4095);
        idle_on = 1'b0;
        f0 = frames_done;
        while (frames_done == f0) random_item(1'b0, cnt);

        // A new frame picks up small dimensions; the middle 192 columns of each row are fetched
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 5);
        idle_on = 1'b1;
        for (int n = 0; n < 300; ) begin
            random_item(1'b1, cnt);
            if (cnt) n++;
        end

        s_valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (err_count == 0) begin
            $display("letterbox_resize_rgb565_to_int8_core_test OK");
        end else begin
            $display("letterbox_resize_rgb565_to_int8_core_test NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/lrs_pkg.sv
src/lrs_div.sv
src/lrs_ctrl.sv
src/lrs_dp.sv
src/letterbox_resize_rgb565_to_int8_core.sv
dv/letterbox_resize_rgb565_to_int8_core_test.sv
